// ===== src/assert_macros.svh =====
// Assertion macros for the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is held.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that is checked in every cycle, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/epmic_pkg.sv =====
// Shared constants, types and gain table function for the crossfader.
`default_nettype none

package epmic_pkg;

    localparam int MAX_CH         = 8;
    localparam int NUM_INPUTS_DEF = 8;
    localparam int FRAC_BITS_DEF  = 12;

    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 15;
    localparam int LAST_W   = 16;
    localparam int GAIN_W   = 17;
    localparam int STEP_W   = 18;
    localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
    localparam int IDX_W    = 3;
    localparam int LG_W     = 4;
    localparam int CNT_W    = 10;

    localparam logic [LG_W-1:0]   LG_RESET   = 4'd8;
    localparam logic [LG_W-1:0]   LG_MAX     = 4'd10;
    localparam logic [LAST_W-1:0] NO_POS     = 16'hFFFF;
    localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'h10000;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          ONE_Q30     = 64'sd1073741824;
    localparam longint unsigned TAYLOR_DIV [7] = '{
        64'd182, 64'd132, 64'd90, 64'd56, 64'd30, 64'd12, 64'd2
    };

    // Control that travels with a frame down the cell chain.
    typedef struct packed {
        logic              block_start;
        logic [IDX_W-1:0]  lo_index;
        logic [IDX_W-1:0]  hi_index;
        logic [LG_W-1:0]   lg;
        logic [GAIN_W-1:0] cos_lo;
        logic [GAIN_W-1:0] cos_hi;
    } frame_ctrl_t;

    // cos(frac * pi/2) in Q16, from a truncating Q30 Taylor series in Horner form.
    function automatic logic [GAIN_W-1:0] quarter_cos(input longint unsigned frac,
                                                      input int frac_bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned p;
        longint          t;
        x  = (frac * HALF_PI_Q30) >> frac_bits;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        for (int k = 0; k < 7; k++) begin
            p = (x2 * 64'(t)) >> 30;
            t = ONE_Q30 - longint'(p / TAYLOR_DIV[k]);
            if (t < 0) begin
                t = 0;
            end
        end
        t = (t + 64'sd8192) >>> 14;
        if (t > 64'sd65536) begin
            t = 64'sd65536;
        end
        return GAIN_W'(t);
    endfunction

endpackage

`default_nettype wire

// ===== src/epmic_decode.sv =====
// Front stage: block counter, position decode and the two gain table reads.
`default_nettype none

module epmic_decode #(
    parameter int NUM_INPUTS    = epmic_pkg::NUM_INPUTS_DEF,
    parameter int FRACTION_BITS = epmic_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire logic                                         cfg_wr_en,
    input  wire logic [epmic_pkg::LG_W-1:0]                   cfg_wr_data,
    input  wire logic                                         adv,
    input  wire logic                                         in_valid,
    input  wire logic [epmic_pkg::POS_W-1:0]                  in_position,
    input  wire logic [NUM_INPUTS-1:0][epmic_pkg::SAMPLE_W-1:0] in_samples,
    output logic                                              out_valid,
    output epmic_pkg::frame_ctrl_t                            out_ctrl,
    output logic [NUM_INPUTS-1:0][epmic_pkg::SAMPLE_W-1:0]    out_samples
);
    import epmic_pkg::*;

    localparam int ROM_DEPTH = (1 << FRACTION_BITS) + 1;
    localparam int ADDR_W    = $clog2(ROM_DEPTH);
    localparam int MAX_POS   = (NUM_INPUTS - 1) << FRACTION_BITS;

    typedef logic [ROM_DEPTH-1:0][GAIN_W-1:0] cos_rom_t;

    function automatic cos_rom_t build_cos_rom();
        cos_rom_t rom;
        rom = '0;
        for (int f = 0; f < ROM_DEPTH; f++) begin
            rom[f] = quarter_cos(longint'(f), FRACTION_BITS);
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

    logic [LG_W-1:0]          blen_reg;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [LAST_W-1:0]        last_pos_reg;
    logic [IDX_W-1:0]         lo_reg, hi_reg;
    logic [FRACTION_BITS-1:0] frac_reg;
    logic                     valid_reg;
    frame_ctrl_t              ctrl_reg;
    logic [NUM_INPUTS-1:0][SAMPLE_W-1:0] samples_reg;

    logic [LG_W-1:0]          lg_eff;
    logic [CNT_W:0]           cnt_inc, blk_len;
    logic                     block_start, accept, pos_update;
    logic [LAST_W-1:0]        pos;
    logic [IDX_W-1:0]         lo_new, hi_new, lo_eff, hi_eff;
    logic [FRACTION_BITS-1:0] frac_new, frac_eff;
    logic [ADDR_W-1:0]        addr_lo, addr_hi;

    assign accept  = in_valid && adv;
    assign lg_eff  = (blen_reg > LG_MAX) ? LG_MAX : blen_reg;
    assign cnt_inc = {1'b0, cnt_reg} + (CNT_W+1)'(1);
    assign blk_len = (CNT_W+1)'(1) << lg_eff;
    assign cnt_next = (cnt_inc >= blk_len) ? '0 : cnt_inc[CNT_W-1:0];
    assign block_start = (cnt_reg == '0);

    always_comb begin
        if (32'(in_position) > MAX_POS) begin
            pos = LAST_W'(MAX_POS);
        end else begin
            pos = {1'b0, in_position};
        end
        lo_new   = IDX_W'(pos >> FRACTION_BITS);
        frac_new = pos[FRACTION_BITS-1:0];
        if (lo_new >= IDX_W'(NUM_INPUTS - 1)) begin
            hi_new = IDX_W'(NUM_INPUTS - 1);
        end else begin
            hi_new = lo_new + IDX_W'(1);
        end
    end

    assign pos_update = block_start && (pos != last_pos_reg);
    assign lo_eff   = pos_update ? lo_new : lo_reg;
    assign hi_eff   = pos_update ? hi_new : hi_reg;
    assign frac_eff = pos_update ? frac_new : frac_reg;
    assign addr_lo  = {1'b0, frac_eff};
    assign addr_hi  = ADDR_W'(ROM_DEPTH - 1) - {1'b0, frac_eff};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blen_reg     <= LG_RESET;
            cnt_reg      <= '0;
            last_pos_reg <= NO_POS;
            lo_reg       <= '0;
            hi_reg       <= '0;
            frac_reg     <= '0;
            valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                blen_reg <= cfg_wr_data;
            end
            if (adv) begin
                valid_reg <= in_valid;
            end
            if (accept) begin
                cnt_reg <= cnt_next;
                if (pos_update) begin
                    last_pos_reg <= pos;
                    lo_reg       <= lo_new;
                    hi_reg       <= hi_new;
                    frac_reg     <= frac_new;
                end
            end
        end
    end

    // Gain table reads and frame payload; registered, no reset needed.
    always_ff @(posedge aclk) begin
        if (accept) begin
            ctrl_reg.block_start <= block_start;
            ctrl_reg.lo_index    <= lo_eff;
            ctrl_reg.hi_index    <= hi_eff;
            ctrl_reg.lg          <= lg_eff;
            ctrl_reg.cos_lo      <= COS_ROM[addr_lo];
            ctrl_reg.cos_hi      <= COS_ROM[addr_hi];
            samples_reg          <= in_samples;
        end
    end

    assign out_valid   = valid_reg;
    assign out_ctrl    = ctrl_reg;
    assign out_samples = samples_reg;

endmodule

`default_nettype wire

// ===== src/epmic_cell.sv =====
// One channel cell: holds the channel's gain ramp and adds its product to the mix.
`default_nettype none

module epmic_cell #(
    parameter int NUM_INPUTS = epmic_pkg::NUM_INPUTS_DEF,
    parameter int CELL_INDEX = 0,
    parameter int SUM_W      = epmic_pkg::PROD_W + 3
) (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire logic                                         adv,
    input  wire logic                                         in_valid,
    input  wire epmic_pkg::frame_ctrl_t                       in_ctrl,
    input  wire logic [NUM_INPUTS-1:0][epmic_pkg::SAMPLE_W-1:0] in_samples,
    input  wire logic signed [SUM_W-1:0]                      in_sum,
    output logic                                              out_valid,
    output epmic_pkg::frame_ctrl_t                            out_ctrl,
    output logic [NUM_INPUTS-1:0][epmic_pkg::SAMPLE_W-1:0]    out_samples,
    output logic signed [SUM_W-1:0]                           out_sum
);
    import epmic_pkg::*;

    localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(CELL_INDEX);

    logic [GAIN_W-1:0]        gain_reg, start_reg;
    logic signed [STEP_W-1:0] step_reg;
    logic                     valid_reg;
    frame_ctrl_t              ctrl_reg;
    logic [NUM_INPUTS-1:0][SAMPLE_W-1:0] samples_reg;
    logic signed [SUM_W-1:0]  sum_reg;

    logic [GAIN_W-1:0]        target, gain_use, gain_next;
    logic signed [STEP_W-1:0] diff, step_use;
    logic signed [STEP_W:0]   gain_sum;
    logic signed [PROD_W-1:0] product;

    always_comb begin
        if (in_ctrl.lo_index == MY_INDEX) begin
            target = in_ctrl.cos_lo;
        end else if (in_ctrl.hi_index == MY_INDEX) begin
            target = in_ctrl.cos_hi;
        end else begin
            target = '0;
        end
        diff     = $signed({1'b0, target}) - $signed({1'b0, start_reg});
        step_use = in_ctrl.block_start ? (diff >>> in_ctrl.lg) : step_reg;
        gain_use = in_ctrl.block_start ? start_reg : gain_reg;
        gain_sum = $signed({2'b00, gain_use}) + $signed({step_use[STEP_W-1], step_use});
        if (gain_sum[STEP_W]) begin
            gain_next = '0;
        end else if (gain_sum[STEP_W-1:0] > STEP_W'(GAIN_UNITY)) begin
            gain_next = GAIN_UNITY;
        end else begin
            gain_next = gain_sum[GAIN_W-1:0];
        end
        product = $signed(in_samples[CELL_INDEX]) * $signed({1'b0, gain_use});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= '0;
            start_reg <= '0;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
            if (in_valid) begin
                gain_reg <= gain_next;
                step_reg <= step_use;
                if (in_ctrl.block_start) begin
                    start_reg <= target;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctrl_reg    <= in_ctrl;
            samples_reg <= in_samples;
            sum_reg     <= in_sum + SUM_W'(product);
        end
    end

    assign out_valid   = valid_reg;
    assign out_ctrl    = ctrl_reg;
    assign out_samples = samples_reg;
    assign out_sum     = sum_reg;

endmodule

`default_nettype wire

// ===== src/equal_power_multi_input_crossfader.sv =====
// Top level of the N-way equal-power crossfader: decode stage, cell chain, output stage.
//
//  Channel | Direction | Handshake          | Word
//  --------+-----------+--------------------+------------------------------------------
//  s_      | in        | s_valid / s_ready  | s_fade_position, s_sample_0 .. s_sample_7
//  m_      | out       | m_valid / m_ready  | m_mixed_sample
//  cfg_    | in        | cfg_wr_en only     | cfg_wr_data (block_len_log2)
//
// One word is taken every cycle while the chain is not held. A word passes the decode stage
// and its gain table read, one register per channel cell, and the register for rounding
// and saturation. The length of the cell chain sets the depth of the pipeline.
// Reset is synchronous and active low; it empties the pipeline, zeroes all gains and sets
// the block length to 256 frames. The gain table is constant and needs no clearing.
// While m_valid is high and m_ready is low the whole chain holds, and s_ready follows as
// (not m_valid) or m_ready, so a word is taken in the same cycle as a finished mix leaves.
`default_nettype none

module equal_power_multi_input_crossfader #(
    parameter int NUM_INPUTS    = epmic_pkg::NUM_INPUTS_DEF,
    parameter int FRACTION_BITS = epmic_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [epmic_pkg::LG_W-1:0]             cfg_wr_data,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [epmic_pkg::POS_W-1:0]            s_fade_position,
    input  wire logic signed [epmic_pkg::SAMPLE_W-1:0]  s_sample_0,
    input  wire logic signed [epmic_pkg::SAMPLE_W-1:0]  s_sample_1,
    input  wire logic signed [epmic_pkg::SAMPLE_W-1:0]  s_sample_2,
    input  wire logic signed [epmic_pkg::SAMPLE_W-1:0]  s_sample_3,
    input  wire logic signed [epmic_pkg::SAMPLE_W-1:0]  s_sample_4,
    input  wire logic signed [epmic_pkg::SAMPLE_W-1:0]  s_sample_5,
    input  wire logic signed [epmic_pkg::SAMPLE_W-1:0]  s_sample_6,
    input  wire logic signed [epmic_pkg::SAMPLE_W-1:0]  s_sample_7,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [epmic_pkg::SAMPLE_W-1:0]       m_mixed_sample
);
    import epmic_pkg::*;

    // The accumulated mix grows by one bit for each doubling of the channel count.
    localparam int SUM_W = PROD_W + $clog2(NUM_INPUTS);

    typedef logic [NUM_INPUTS-1:0][SAMPLE_W-1:0] samples_t;

    logic [MAX_CH-1:0][SAMPLE_W-1:0] port_samples;
    samples_t                        frame_samples;

    // Chain links: entry 0 is the decode stage, entry i+1 is the output of cell i.
    logic                    chain_valid   [NUM_INPUTS+1];
    frame_ctrl_t             chain_ctrl    [NUM_INPUTS+1];
    samples_t                chain_samples [NUM_INPUTS+1];
    logic signed [SUM_W-1:0] chain_sum     [NUM_INPUTS+1];

    logic                    adv;
    logic                    m_valid_reg;
    logic signed [SAMPLE_W-1:0] mix_reg, mix_next;
    logic signed [SUM_W-1:0] rounded, shifted;

    // The whole pipeline moves on together whenever the output register can be refilled.
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Channels beyond NUM_INPUTS are dropped here and never reach the cells.
    assign port_samples = {s_sample_7, s_sample_6, s_sample_5, s_sample_4,
                           s_sample_3, s_sample_2, s_sample_1, s_sample_0};
    assign frame_samples = port_samples[NUM_INPUTS-1:0];

    epmic_decode #(
        .NUM_INPUTS    (NUM_INPUTS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .adv         (adv),
        .in_valid    (s_valid),
        .in_position (s_fade_position),
        .in_samples  (frame_samples),
        .out_valid   (chain_valid[0]),
        .out_ctrl    (chain_ctrl[0]),
        .out_samples (chain_samples[0])
    );

    assign chain_sum[0] = '0;

    // Each cell owns one channel's gain ramp and adds its product to the running mix
    // before passing the frame on to its neighbour.
    for (genvar i = 0; i < NUM_INPUTS; i++) begin : g_cell
        epmic_cell #(
            .NUM_INPUTS (NUM_INPUTS),
            .CELL_INDEX (i),
            .SUM_W      (SUM_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .adv         (adv),
            .in_valid    (chain_valid[i]),
            .in_ctrl     (chain_ctrl[i]),
            .in_samples  (chain_samples[i]),
            .in_sum      (chain_sum[i]),
            .out_valid   (chain_valid[i+1]),
            .out_ctrl    (chain_ctrl[i+1]),
            .out_samples (chain_samples[i+1]),
            .out_sum     (chain_sum[i+1])
        );
    end

    // Round half up to Q1.15 (an arithmetic shift is a floor), then saturate.
    always_comb begin
        rounded = chain_sum[NUM_INPUTS] + SUM_W'(32'sd32768);
        shifted = rounded >>> 16;
        if (shifted > SUM_W'(32'sd32767)) begin
            mix_next = 16'sh7FFF;
        end else if (shifted < SUM_W'(-32'sd32768)) begin
            mix_next = 16'sh8000;
        end else begin
            mix_next = shifted[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= chain_valid[NUM_INPUTS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && chain_valid[NUM_INPUTS]) begin
            mix_reg <= mix_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_mixed_sample = mix_reg;

endmodule

`default_nettype wire

// ===== src/epmic_checker.sv =====
// Port-level checker for the crossfader and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module epmic_checker (
    input wire logic                                  aclk,
    input wire logic                                  aresetn,
    input wire logic                                  s_valid,
    input wire logic                                  s_ready,
    input wire logic                                  m_valid,
    input wire logic                                  m_ready,
    input wire logic signed [epmic_pkg::SAMPLE_W-1:0] m_mixed_sample
);

    // A mix that is waiting must not change or vanish.
    `ASSERT_CLK_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_mixed_sample), "mix changed while stalled")

    // The input side only waits while a finished mix is held back.
    `ASSERT_CLK_RST(a_ready_rule, aclk, aresetn, s_ready == (!m_valid || m_ready), "s_ready does not follow the output stage")

    // Reset empties the pipeline.
    `ASSERT_CLK(a_reset_empty, aclk, !aresetn |=> !m_valid, "m_valid high straight after reset")

    // A word taken while a mix is waiting implies the pipeline kept moving.
    `ASSERT_CLK_RST(a_accept_moves, aclk, aresetn, s_valid && s_ready && m_valid |-> m_ready, "word taken while output stalled")

endmodule

bind equal_power_multi_input_crossfader epmic_checker u_epmic_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the equal-power multi-input crossfader.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import epmic_pkg::*;

    // The block is built with its default channel count and fraction width.
    localparam int NUM_CH    = NUM_INPUTS_DEF;
    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int MAX_POS   = (NUM_CH - 1) << FRAC;
    // Decode stage, one cell per channel and the output stage.
    localparam int LATENCY   = NUM_CH + 2;
    localparam int FRAC_ONE  = 1 << FRAC;

    // One input word: the fade position and one sample per channel.
    typedef struct packed {
        logic [POS_W-1:0]                   position;
        logic [MAX_CH-1:0][SAMPLE_W-1:0]    sample;
    } frame_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                       cfg_wr_en   = 1'b0;
    logic [LG_W-1:0]            cfg_wr_data = '0;
    logic                       s_valid     = 1'b0;
    logic                       s_ready;
    logic [POS_W-1:0]           s_fade_position = '0;
    logic signed [SAMPLE_W-1:0] s_sample_0 = '0;
    logic signed [SAMPLE_W-1:0] s_sample_1 = '0;
    logic signed [SAMPLE_W-1:0] s_sample_2 = '0;
    logic signed [SAMPLE_W-1:0] s_sample_3 = '0;
    logic signed [SAMPLE_W-1:0] s_sample_4 = '0;
    logic signed [SAMPLE_W-1:0] s_sample_5 = '0;
    logic signed [SAMPLE_W-1:0] s_sample_6 = '0;
    logic signed [SAMPLE_W-1:0] s_sample_7 = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_mixed_sample;

    // Percentages of cycles in which each side holds back, and the length of
    // a forced stall of the result side, counted down by the receiver process.
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int stall_left        = 0;
    int error_count       = 0;

    // Mixes still owed by the block, oldest first.
    logic signed [SAMPLE_W-1:0] mix_queue [$];
    logic signed [SAMPLE_W-1:0] mix_want;

    // Mirror of the crossfader's state, advanced once per accepted word.
    logic [LG_W-1:0]          blk_lg = LG_RESET;
    logic [GAIN_W-1:0]        gain_now    [MAX_CH];
    logic [GAIN_W-1:0]        gain_target [MAX_CH];
    logic signed [STEP_W-1:0] gain_step   [MAX_CH];
    int                       frame_idx = 0;
    logic [2:0]               lo_ch = '0;
    logic [2:0]               hi_ch = '0;
    logic [FRAC-1:0]          fade_frac = '0;
    logic [LAST_W-1:0]        held_pos = NO_POS;
    logic [POS_W-1:0]         last_sent_pos = '0;

    equal_power_multi_input_crossfader i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_fade_position (s_fade_position),
        .s_sample_0      (s_sample_0),
        .s_sample_1      (s_sample_1),
        .s_sample_2      (s_sample_2),
        .s_sample_3      (s_sample_3),
        .s_sample_4      (s_sample_4),
        .s_sample_5      (s_sample_5),
        .s_sample_6      (s_sample_6),
        .s_sample_7      (s_sample_7),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_mixed_sample  (m_mixed_sample)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // cos(frac * pi/2) in Q16. The angle is formed in Q30, the cosine comes
    // from the Taylor series to the fourteenth power in nested form with
    // truncating arithmetic, and the result is rounded to Q16 and capped at one.
    // The divisors of the nested form are 14*13, 12*11, ... down to 2*1.
    function automatic logic [GAIN_W-1:0] eq_power_gain(input int unsigned frac);
        longint unsigned angle;
        longint unsigned angle_sq;
        longint unsigned prod;
        longint          term;
        angle    = (64'(frac) * HALF_PI_Q30) >> FRAC;
        angle_sq = (angle * angle) >> 30;
        term     = ONE_Q30;
        for (int k = 0; k < 7; k++) begin
            prod = (angle_sq * 64'(term)) >> 30;
            term = ONE_Q30 - longint'(prod / 64'((14 - 2 * k) * (13 - 2 * k)));
            if (term < 0) begin
                term = 0;
            end
        end
        term = (term + 64'sd8192) >>> 14;
        if (term > longint'(GAIN_UNITY)) begin
            term = longint'(GAIN_UNITY);
        end
        return GAIN_W'(term);
    endfunction

    // Works out the mix for one accepted word and moves the mirrored state on.
    function automatic logic signed [SAMPLE_W-1:0] predict_mix(input frame_t f);
        int               lg_eff;
        int               tgt;
        int               base;
        int               g;
        longint           acc;
        logic [POS_W-1:0] pos;
        lg_eff = (blk_lg > LG_MAX) ? int'(LG_MAX) : int'(blk_lg);
        acc    = 0;
        if (frame_idx == 0) begin
            // Start of a block: decode the clamped position only if it moved,
            // but retarget every channel in any case.
            pos = f.position;
            if (pos > MAX_POS) begin
                pos = POS_W'(MAX_POS);
            end
            if ({1'b0, pos} != held_pos) begin
                held_pos  = {1'b0, pos};
                lo_ch     = 3'(pos >> FRAC);
                hi_ch     = (int'(lo_ch) == NUM_CH - 1) ? lo_ch : lo_ch + 3'd1;
                fade_frac = pos[FRAC-1:0];
            end
            for (int ch = 0; ch < NUM_CH; ch++) begin
                tgt = 0;
                if (ch == int'(lo_ch)) begin
                    tgt = int'(eq_power_gain(fade_frac));
                end else if (ch == int'(hi_ch)) begin
                    tgt = int'(eq_power_gain(FRAC_ONE - int'(fade_frac)));
                end
                base             = int'(gain_target[ch]);
                gain_step[ch]    = STEP_W'((tgt - base) >>> lg_eff);
                gain_now[ch]     = GAIN_W'(base);
                gain_target[ch]  = GAIN_W'(tgt);
            end
        end
        for (int ch = 0; ch < NUM_CH; ch++) begin
            acc = acc + longint'($signed(f.sample[ch])) * longint'(gain_now[ch]);
            g   = int'(gain_now[ch]) + int'(gain_step[ch]);
            if (g < 0) begin
                g = 0;
            end
            if (g > int'(GAIN_UNITY)) begin
                g = int'(GAIN_UNITY);
            end
            gain_now[ch] = GAIN_W'(g);
        end
        // Round half up to Q1.15, then saturate.
        acc = (acc + 64'sd32768) >>> 16;
        if (acc > 32767) begin
            acc = 32767;
        end
        if (acc < -32768) begin
            acc = -32768;
        end
        frame_idx++;
        if (frame_idx >= (1 << lg_eff)) begin
            frame_idx = 0;
        end
        return SAMPLE_W'(acc);
    endfunction

    function automatic frame_t fill_frame(input int pos, input int even_val, input int odd_val);
        frame_t f;
        f.position = POS_W'(pos);
        for (int ch = 0; ch < MAX_CH; ch++) begin
            f.sample[ch] = SAMPLE_W'((ch % 2 == 0) ? even_val : odd_val);
        end
        return f;
    endfunction

    // Positions favour repeats, exact channel boundaries and values past the
    // last channel; samples favour full scale so that the mix saturates often.
    function automatic frame_t random_frame();
        frame_t f;
        case ($urandom_range(7))
            0, 1:    f.position = last_sent_pos;
            2:       f.position = POS_W'($urandom_range(NUM_CH - 1) << FRAC);
            3:       f.position = POS_W'($urandom_range(32767, MAX_POS + 1));
            default: f.position = POS_W'($urandom_range(MAX_POS));
        endcase
        for (int ch = 0; ch < MAX_CH; ch++) begin
            case ($urandom_range(7))
                0:       f.sample[ch] = 16'h7FFF;
                1:       f.sample[ch] = 16'h8000;
                2:       f.sample[ch] = SAMPLE_W'($urandom_range(255));
                default: f.sample[ch] = SAMPLE_W'($urandom);
            endcase
        end
        return f;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Offers one word, after a random gap if the sender is idling, and holds
    // it until the block takes it. Each cycle of the gap is idle with the
    // sender's idle percentage. Valid is left high for the next word; a
    // following gap or idle wait lowers it on a later falling edge.
    task automatic send_frame(input frame_t f);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_fade_position <= f.position;
        s_sample_0      <= f.sample[0];
        s_sample_1      <= f.sample[1];
        s_sample_2      <= f.sample[2];
        s_sample_3      <= f.sample[3];
        s_sample_4      <= f.sample[4];
        s_sample_5      <= f.sample[5];
        s_sample_6      <= f.sample[6];
        s_sample_7      <= f.sample[7];
        do @(posedge aclk); while (!s_ready);
        last_sent_pos = f.position;
        mix_queue.push_back(predict_mix(f));
    endtask

    // Stops offering words and waits until every owed mix has come out, so
    // the pipeline is empty. Every word yields a mix, so nothing is left in
    // flight once the queue is empty.
    task automatic wait_for_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (mix_queue.size() != 0) @(posedge aclk);
    endtask

    // Writes the block length register; only ever called with the block idle.
    task automatic write_block_len(input int value);
        wait_for_idle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= LG_W'(value);
        @(posedge aclk);
        blk_lg = LG_W'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // A few words with the block length left at its reset value, so the
    // gains ramp slowly up from zero.
    task automatic test_reset_block_length();
        for (int n = 0; n < 4; n++) begin
            send_frame(random_frame());
        end
    endtask

    // With a block length of one frame every word is a block start. The
    // positions cover the first channel, a midpoint where both gains sit near
    // 0.707 (full-scale samples then saturate both ways), a repeated position,
    // the last channel exactly, a position past it that is clamped, and
    // fractions at both ends of their range.
    task automatic test_position_extremes();
        write_block_len(0);
        send_frame(fill_frame(0, 32767, 32767));
        send_frame(fill_frame(0, -32768, -32768));
        send_frame(fill_frame(2048, 32767, 32767));
        send_frame(fill_frame(2048, 32767, 32767));
        send_frame(fill_frame(2048, -32768, -32768));
        send_frame(fill_frame(2048, 32767, -32768));
        send_frame(fill_frame(MAX_POS, 1234, -1234));
        send_frame(fill_frame(32767, 32767, -32768));
        send_frame(fill_frame(32767, -32768, 32767));
        send_frame(fill_frame(4095, 16384, -16384));
        send_frame(fill_frame(4096, -1, 1));
        send_frame(fill_frame(MAX_POS - 1, 32767, 32767));
        send_frame(fill_frame(12288, 0, 0));
        send_frame(fill_frame(1, 32767, -1));
    endtask

    // Shortens the block while the frame counter is already past the new
    // length, so the block ends early and the next ramp starts from the old
    // target; then lengthens it again at the start of a block.
    task automatic test_block_change_mid_block();
        write_block_len(2);
        repeat (3) send_frame(random_frame());
        write_block_len(1);
        repeat (3) send_frame(random_frame());
        write_block_len(3);
        repeat (2) send_frame(random_frame());
    endtask

    // Random words in several register settings, with the extremes first.
    // At least half the settings are short blocks so that block starts come often.
    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int lg;
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0:       lg = 0;
                1:       lg = 15;
                2:       lg = int'(LG_MAX);
                default: lg = (phase % 2 == 0) ? $urandom_range(15) : $urandom_range(4);
            endcase
            write_block_len(lg);
            repeat ($urandom_range(30, 75)) send_frame(random_frame());
        end
    endtask

    // The result side is held off for a long stretch while words keep
    // coming, so the pipeline fills and the block must stall its input.
    task automatic test_output_backpressure();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_block_len(2);
        stall_left = 300;
        repeat (60) send_frame(random_frame());
    endtask

    // Result side: ready idles at random unless a forced stall is running.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Each mix that leaves the block is matched against the oldest one owed.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (mix_queue.size() == 0) begin
                report_mismatch("unexpected mixed_sample", int'(m_mixed_sample), 0);
            end else begin
                mix_want = mix_queue.pop_front();
                if (m_mixed_sample !== mix_want) begin
                    report_mismatch("mixed_sample", int'(m_mixed_sample), int'(mix_want));
                end
            end
        end
    end

    initial begin
        for (int ch = 0; ch < MAX_CH; ch++) begin
            gain_now[ch]    = '0;
            gain_target[ch] = '0;
            gain_step[ch]   = '0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_block_length();
        test_position_extremes();
        test_block_change_mid_block();
        test_random_traffic(20, 77);
        test_random_traffic(77, 20);
        test_random_traffic(0, 0);
        test_output_backpressure();

        // Drain, then give the block time to show any stray extra word.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        wait_for_idle();
        repeat (4 * LATENCY) @(posedge aclk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hard limit on the run, far beyond the slowest correct run.
    initial begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
